// ----- design/llca_pkg.sv -----
// ---------------------------------------------------------------------------
// llca_pkg
// Shared types and constants for the life-like cellular automaton block.
// ---------------------------------------------------------------------------
package llca_pkg;

   // field widths
   localparam int KIND_W     = 2;
   localparam int COORD_W    = 8;
   localparam int GRID_REG_W = 7;
   localparam int MASK_W     = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // register reset values (b3/s23)
   localparam logic [GRID_REG_W-1:0] GRID_WIDTH_RST   = 7'd64;
   localparam logic [GRID_REG_W-1:0] GRID_HEIGHT_RST  = 7'd64;
   localparam logic                  EDGE_WRAP_RST    = 1'b0;
   localparam logic [MASK_W-1:0]     BIRTH_MASK_RST   = 9'd8;
   localparam logic [MASK_W-1:0]     SURVIVE_MASK_RST = 9'd12;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRID_WIDTH   = 3'd0,
      CSR_GRID_HEIGHT  = 3'd1,
      CSR_EDGE_WRAP    = 3'd2,
      CSR_BIRTH_MASK   = 3'd3,
      CSR_SURVIVE_MASK = 3'd4
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TOGGLE  = 2'd0,
      KIND_CLEAR   = 2'd1,
      KIND_ADVANCE = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_MOD,
      S_ACC_RD,
      S_ACC_WR,
      S_CLEAR,
      S_GEN_LAST,
      S_GEN_FIRST,
      S_GEN_LOAD,
      S_GEN_ROW,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MOD,
      OP_CLEAR,
      OP_ACC_RD,
      OP_ACC_WR,
      OP_GEN_LAST,
      OP_GEN_FIRST,
      OP_GEN_LOAD,
      OP_GEN_ROW
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      res_load;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     wrap;
      logic     in_range;
      logic     row_last_max;
      logic     row_last_act;
      logic     slot_free;
   } sts_type;

endpackage

// ----- design/llca_dp.sv -----
// ---------------------------------------------------------------------------
// llca_dp
// Datapath: config registers, row-wide cell memory, coordinate modulo unit,
// one-row-per-cycle generation lanes and the result register.
// ---------------------------------------------------------------------------
module llca_dp #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  llca_pkg::cmd_type                   cmd,
   output llca_pkg::sts_type                   sts,
   input  llca_pkg::kind_type                  req_kind,
   input  logic [llca_pkg::COORD_W-1:0]        req_col,
   input  logic [llca_pkg::COORD_W-1:0]        req_row,
   input  logic                                csr_valid,
   input  logic [llca_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [llca_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic                                rsp_ok,
   output logic                                rsp_cell_value
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CXW = $clog2(MAX_COLS + 1);
   localparam int RXW = $clog2(MAX_ROWS + 1);
   localparam int XW0 = (CXW > RXW) ? CXW : RXW;
   localparam int XW  = (XW0 > llca_pkg::COORD_W) ? XW0 : llca_pkg::COORD_W;
   localparam int DW  = XW + llca_pkg::COORD_W - 1;

   // config registers
   logic [llca_pkg::GRID_REG_W-1:0] gw_ff, gw_in, gh_ff, gh_in;
   logic                            wrap_ff, wrap_in;
   logic [llca_pkg::MASK_W-1:0]     birth_ff, birth_in, surv_ff, surv_in;

   // item registers
   llca_pkg::kind_type kind_ff, kind_in;
   logic [XW-1:0]      rem_col_ff, rem_col_in, rem_row_ff, rem_row_in;
   logic [DW-1:0]      div_col_ff, div_col_in, div_row_ff, div_row_in;
   logic               res_ok_ff, res_ok_in, res_val_ff, res_val_in;

   // generation window
   logic [RW-1:0]       rc_ff, rc_in;
   logic [MAX_COLS-1:0] above_ff, above_in, cur_ff, cur_in, first_ff, first_in;
   logic [MAX_COLS-1:0] below, new_row;

   // result register
   logic rsp_valid_ff, rsp_valid_in, rsp_ok_ff, rsp_ok_in, rsp_val_ff, rsp_val_in;

   // cell memory, one row per word
   logic [MAX_COLS-1:0] mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rdata_ff, mem_wd;
   logic [RW-1:0]       mem_wa, mem_ra;
   logic                mem_we, mem_re;

   logic [XW-1:0] gw_x, gh_x, aw, ah, aw_m1, ah_m1, nxt1, nxt2;
   logic          row_last_max, row_last_act, hit, toggle, coord_op;

   assign gw_x = XW'(gw_ff);
   assign gh_x = XW'(gh_ff);

   // active size, zero taken as one, saturated at the maximum
   always_comb begin
      if (gw_ff == '0)                aw = XW'(1);
      else if (gw_x > XW'(MAX_COLS))  aw = XW'(MAX_COLS);
      else                            aw = gw_x;
      if (gh_ff == '0)                ah = XW'(1);
      else if (gh_x > XW'(MAX_ROWS))  ah = XW'(MAX_ROWS);
      else                            ah = gh_x;
   end

   assign aw_m1        = aw - XW'(1);
   assign ah_m1        = ah - XW'(1);
   assign nxt1         = XW'(rc_ff) + XW'(1);
   assign nxt2         = XW'(rc_ff) + XW'(2);
   assign row_last_max = (rc_ff == RW'(MAX_ROWS - 1));
   assign row_last_act = (XW'(rc_ff) == ah_m1);
   assign hit          = rdata_ff[rem_col_ff[CW-1:0]];
   assign toggle       = (kind_ff == llca_pkg::KIND_TOGGLE);
   assign coord_op     = (req_kind == llca_pkg::KIND_TOGGLE) ||
                         (req_kind == llca_pkg::KIND_READ);

   // row below the one being updated
   assign below = row_last_act ? (wrap_ff ? first_ff : '0) : rdata_ff;

   // neighbour lanes
   logic [MAX_COLS-1:0] win [3];
   logic [2:0]          fold_l, fold_r;

   assign win[0] = above_ff;
   assign win[1] = cur_ff;
   assign win[2] = below;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fold_l[k] = wrap_ff & win[k][aw_m1[CW-1:0]];
         fold_r[k] = wrap_ff & win[k][0];
      end
   end

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
      logic [2:0]                  lv, rv;
      logic [3:0]                  cnt;
      logic [llca_pkg::MASK_W-1:0] rule;
      logic                        act;

      if (c == 0) begin : g_l
         assign lv = fold_l;
      end else begin : g_l
         assign lv = {win[2][c-1], win[1][c-1], win[0][c-1]};
      end

      if (c == MAX_COLS - 1) begin : g_r
         assign rv = fold_r;
      end else begin : g_r
         assign rv = (XW'(c) == aw_m1) ? fold_r : {win[2][c+1], win[1][c+1], win[0][c+1]};
      end

      assign cnt = 4'(lv[0]) + 4'(win[0][c]) + 4'(rv[0]) + 4'(lv[1]) + 4'(rv[1]) +
                   4'(lv[2]) + 4'(win[2][c]) + 4'(rv[2]);
      assign rule = win[1][c] ? surv_ff : birth_ff;
      assign act  = (XW'(c) < aw);
      assign new_row[c] = act ? rule[cnt] : win[1][c];
   end

   always_comb begin
      gw_in    = gw_ff;
      gh_in    = gh_ff;
      wrap_in  = wrap_ff;
      birth_in = birth_ff;
      surv_in  = surv_ff;
      if (csr_valid) begin
         case (csr_addr)
            llca_pkg::CSR_GRID_WIDTH:   gw_in    = csr_data[llca_pkg::GRID_REG_W-1:0];
            llca_pkg::CSR_GRID_HEIGHT:  gh_in    = csr_data[llca_pkg::GRID_REG_W-1:0];
            llca_pkg::CSR_EDGE_WRAP:    wrap_in  = csr_data[0];
            llca_pkg::CSR_BIRTH_MASK:   birth_in = csr_data[llca_pkg::MASK_W-1:0];
            llca_pkg::CSR_SURVIVE_MASK: surv_in  = csr_data[llca_pkg::MASK_W-1:0];
            default: ;
         endcase
      end

      kind_in    = kind_ff;
      rem_col_in = rem_col_ff;
      rem_row_in = rem_row_ff;
      div_col_in = div_col_ff;
      div_row_in = div_row_ff;
      res_ok_in  = res_ok_ff;
      res_val_in = res_val_ff;
      rc_in      = rc_ff;
      above_in   = above_ff;
      cur_in     = cur_ff;
      first_in   = first_ff;
      mem_we     = 1'b0;
      mem_wa     = rc_ff;
      mem_wd     = '0;
      mem_re     = 1'b0;
      mem_ra     = rc_ff;

      unique case (cmd.op)
         llca_pkg::OP_NONE: ;
         llca_pkg::OP_LOAD: begin
            kind_in    = req_kind;
            rem_col_in = XW'(req_col);
            rem_row_in = XW'(req_row);
            div_col_in = DW'(aw) << (llca_pkg::COORD_W - 1);
            div_row_in = DW'(ah) << (llca_pkg::COORD_W - 1);
            res_val_in = 1'b0;
            res_ok_in  = !coord_op || wrap_ff ||
                         ((XW'(req_col) < aw) && (XW'(req_row) < ah));
         end
         llca_pkg::OP_MOD: begin
            // one restoring step per cycle for both coordinates
            if (DW'(rem_col_ff) >= div_col_ff) rem_col_in = rem_col_ff - div_col_ff[XW-1:0];
            if (DW'(rem_row_ff) >= div_row_ff) rem_row_in = rem_row_ff - div_row_ff[XW-1:0];
            div_col_in = div_col_ff >> 1;
            div_row_in = div_row_ff >> 1;
         end
         llca_pkg::OP_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = rc_ff;
            mem_wd = '0;
            rc_in  = row_last_max ? '0 : rc_ff + RW'(1);
         end
         llca_pkg::OP_ACC_RD: begin
            mem_re = 1'b1;
            mem_ra = rem_row_ff[RW-1:0];
         end
         llca_pkg::OP_ACC_WR: begin
            res_val_in = hit ^ toggle;
            if (toggle) begin
               mem_we = 1'b1;
               mem_wa = rem_row_ff[RW-1:0];
               mem_wd = rdata_ff ^ (MAX_COLS'(1) << rem_col_ff[CW-1:0]);
            end
         end
         llca_pkg::OP_GEN_LAST: begin
            mem_re = 1'b1;
            mem_ra = ah_m1[RW-1:0];
            rc_in  = '0;
         end
         llca_pkg::OP_GEN_FIRST: begin
            mem_re   = 1'b1;
            mem_ra   = '0;
            above_in = wrap_ff ? rdata_ff : '0;
         end
         llca_pkg::OP_GEN_LOAD: begin
            cur_in   = rdata_ff;
            first_in = rdata_ff;
            mem_re   = (nxt1 < ah);
            mem_ra   = nxt1[RW-1:0];
         end
         llca_pkg::OP_GEN_ROW: begin
            mem_we   = 1'b1;
            mem_wa   = rc_ff;
            mem_wd   = new_row;
            above_in = cur_ff;
            cur_in   = below;
            rc_in    = row_last_act ? '0 : rc_ff + RW'(1);
            mem_re   = (nxt2 < ah);
            mem_ra   = nxt2[RW-1:0];
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_val_in   = rsp_val_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_val_in   = res_val_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff        <= llca_pkg::GRID_WIDTH_RST;
         gh_ff        <= llca_pkg::GRID_HEIGHT_RST;
         wrap_ff      <= llca_pkg::EDGE_WRAP_RST;
         birth_ff     <= llca_pkg::BIRTH_MASK_RST;
         surv_ff      <= llca_pkg::SURVIVE_MASK_RST;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         wrap_ff      <= wrap_in;
         birth_ff     <= birth_in;
         surv_ff      <= surv_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      rem_col_ff <= rem_col_in;
      rem_row_ff <= rem_row_in;
      div_col_ff <= div_col_in;
      div_row_ff <= div_row_in;
      res_ok_ff  <= res_ok_in;
      res_val_ff <= res_val_in;
      above_ff   <= above_in;
      cur_ff     <= cur_in;
      first_ff   <= first_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_val_ff <= rsp_val_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= mem[mem_ra];
   end

   assign sts.kind         = kind_ff;
   assign sts.wrap         = wrap_ff;
   assign sts.in_range     = res_ok_ff;
   assign sts.row_last_max = row_last_max;
   assign sts.row_last_act = row_last_act;
   assign sts.slot_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_cell_value = rsp_val_ff;

   // the row being rewritten must never be the row fetched ahead
   a_gen_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == llca_pkg::OP_GEN_ROW && mem_re) |-> (mem_ra != mem_wa))
      else $error("generation prefetch hits the row being written");

endmodule

// ----- design/llca_ctrl.sv -----
// ---------------------------------------------------------------------------
// llca_ctrl
// Controller: sequences clear sweeps, cell access and generation passes.
// ---------------------------------------------------------------------------
module llca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output llca_pkg::cmd_type cmd,
   input  llca_pkg::sts_type sts
);

   localparam int MCW = $clog2(llca_pkg::COORD_W);
   localparam logic [MCW-1:0] MOD_LAST = MCW'(llca_pkg::COORD_W - 1);

   llca_pkg::state_type state_ff, state_in;
   logic [MCW-1:0]      mod_cnt_ff, mod_cnt_in;
   logic                accept;

   assign accept = req_tvalid && (state_ff == llca_pkg::S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         llca_pkg::S_INIT:      if (sts.row_last_max) state_in = llca_pkg::S_IDLE;
         llca_pkg::S_IDLE:      if (accept) state_in = llca_pkg::S_DISPATCH;
         llca_pkg::S_DISPATCH: begin
            unique case (sts.kind) inside
               llca_pkg::KIND_CLEAR:   state_in = llca_pkg::S_CLEAR;
               llca_pkg::KIND_ADVANCE: state_in = llca_pkg::S_GEN_LAST;
               llca_pkg::KIND_TOGGLE, llca_pkg::KIND_READ: begin
                  if (sts.wrap)          state_in = llca_pkg::S_MOD;
                  else if (sts.in_range) state_in = llca_pkg::S_ACC_RD;
                  else                   state_in = llca_pkg::S_DONE;
               end
               default: state_in = llca_pkg::S_DONE;
            endcase
         end
         llca_pkg::S_MOD:       if (mod_cnt_ff == MOD_LAST) state_in = llca_pkg::S_ACC_RD;
         llca_pkg::S_ACC_RD:    state_in = llca_pkg::S_ACC_WR;
         llca_pkg::S_ACC_WR:    state_in = llca_pkg::S_DONE;
         llca_pkg::S_CLEAR:     if (sts.row_last_max) state_in = llca_pkg::S_DONE;
         llca_pkg::S_GEN_LAST:  state_in = llca_pkg::S_GEN_FIRST;
         llca_pkg::S_GEN_FIRST: state_in = llca_pkg::S_GEN_LOAD;
         llca_pkg::S_GEN_LOAD:  state_in = llca_pkg::S_GEN_ROW;
         llca_pkg::S_GEN_ROW:   if (sts.row_last_act) state_in = llca_pkg::S_DONE;
         llca_pkg::S_DONE:      if (sts.slot_free) state_in = llca_pkg::S_IDLE;
         default:               state_in = llca_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op       = llca_pkg::OP_NONE;
      cmd.res_load = 1'b0;
      req_tready   = 1'b0;
      unique case (state_ff)
         llca_pkg::S_INIT:      cmd.op = llca_pkg::OP_CLEAR;
         llca_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (accept) cmd.op = llca_pkg::OP_LOAD;
         end
         llca_pkg::S_DISPATCH:  cmd.op = llca_pkg::OP_NONE;
         llca_pkg::S_MOD:       cmd.op = llca_pkg::OP_MOD;
         llca_pkg::S_ACC_RD:    cmd.op = llca_pkg::OP_ACC_RD;
         llca_pkg::S_ACC_WR:    cmd.op = llca_pkg::OP_ACC_WR;
         llca_pkg::S_CLEAR:     cmd.op = llca_pkg::OP_CLEAR;
         llca_pkg::S_GEN_LAST:  cmd.op = llca_pkg::OP_GEN_LAST;
         llca_pkg::S_GEN_FIRST: cmd.op = llca_pkg::OP_GEN_FIRST;
         llca_pkg::S_GEN_LOAD:  cmd.op = llca_pkg::OP_GEN_LOAD;
         llca_pkg::S_GEN_ROW:   cmd.op = llca_pkg::OP_GEN_ROW;
         llca_pkg::S_DONE:      cmd.res_load = sts.slot_free;
         default: ;
      endcase
   end

   assign mod_cnt_in = (state_ff == llca_pkg::S_MOD) ? mod_cnt_ff + MCW'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= llca_pkg::S_INIT;
         mod_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mod_cnt_ff <= mod_cnt_in;
      end
   end

   // read data is only consumed in the cycle after its fetch
   a_acc_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == llca_pkg::S_ACC_WR) |-> ($past(state_ff) == llca_pkg::S_ACC_RD))
      else $error("cell write-back without a preceding read");

   a_row_after_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == llca_pkg::S_GEN_ROW) |->
      ($past(state_ff) == llca_pkg::S_GEN_LOAD || $past(state_ff) == llca_pkg::S_GEN_ROW))
      else $error("generation row step entered without its window loaded");

   // wrapped coordinates always land on the grid
   a_wrap_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == llca_pkg::S_DISPATCH && sts.wrap) |-> sts.in_range)
      else $error("wrap mode item flagged off grid");

   a_mod_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == llca_pkg::S_ACC_RD && $past(state_ff) == llca_pkg::S_MOD) |->
      ($past(mod_cnt_ff) == MOD_LAST))
      else $error("coordinate reduction cut short");

endmodule

// ----- design/life_like_cellular_automaton_top.sv -----
// ---------------------------------------------------------------------------
// life_like_cellular_automaton_top
// Life-like automaton on a MAX_COLS x MAX_ROWS one-bit grid with b/s masks.
// ---------------------------------------------------------------------------
// sequence: toggle/read run the 8 modulo steps first in wrap mode and skip the cell access
//    when off grid; clear sweeps all MAX_ROWS rows; advance updates one row per cycle
// flow: one word in flight, the next is taken in the cycle after its result is loaded; a
//    stalled rsp side holds req back once a second result is ready behind the output register
// reset: synchronous; a clearing pass over all rows follows with req_tready low, csr taken
module life_like_cellular_automaton_top #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [llca_pkg::REQ_DATA_W-1:0]     req_tdata,   // col[7:0], row[15:8]
   input  logic [llca_pkg::KIND_W-1:0]         req_tuser,   // kind[1:0]
   // response words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [llca_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // ok[0], cell_value[1], zero[7:2]
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [llca_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [llca_pkg::CSR_DATA_W-1:0]     csr_data
);

   llca_pkg::cmd_type cmd;
   llca_pkg::sts_type sts;
   logic              rsp_ok, rsp_cell_value;

   // register writes are always accepted and land in the next cycle
   assign csr_ready = 1'b1;

   // controller: state machine and modulo step counter
   llca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: grid memory, lanes, config and result registers
   llca_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (llca_pkg::kind_type'(req_tuser)),
      .req_col        (req_tdata[llca_pkg::COORD_W-1:0]),
      .req_row        (req_tdata[2*llca_pkg::COORD_W-1:llca_pkg::COORD_W]),
      .csr_valid      (csr_valid && csr_ready),
      .csr_addr       (csr_addr),
      .csr_data       (csr_data),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_ok         (rsp_ok),
      .rsp_cell_value (rsp_cell_value)
   );

   // response packing, low bit first
   assign rsp_tdata = {{(llca_pkg::RSP_DATA_W-2){1'b0}}, rsp_cell_value, rsp_ok};

endmodule

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the life-like cellular automaton block. A directed
// table covers reset state, grid edges, every kind of word, the wrap and
// saturation corners of the grid registers and tiny toroidal grids. Random
// phases with fresh register settings follow. Every reply is checked against
// a cell-grid predictor kept inside the bench, or against the reply the table gives.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int RAND_PHASES     = 6;
   localparam int WORDS_PER_PHASE = 20;

   // one reply: ok and the cell value
   typedef struct packed {
      bit ok;
      bit cell_value;
   } cell_reply_type;

   // one line of the directed table: a register write or a request word,
   // optionally with a reply that is known up front
   typedef struct packed {
      bit                      is_csr;
      llca_pkg::csr_index_type addr;
      logic [8:0]              value;
      llca_pkg::kind_type      kind;
      logic [7:0]              col;
      logic [7:0]              row;
      bit                      known;
      bit                      exp_ok;
      bit                      exp_val;
   } stim_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [llca_pkg::REQ_DATA_W-1:0] req_tdata;   // col[7:0], row[15:8]
   logic [llca_pkg::KIND_W-1:0]     req_tuser;   // kind[1:0]
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [llca_pkg::RSP_DATA_W-1:0] rsp_tdata;   // ok[0], cell_value[1], zero[7:2]
   logic                            csr_valid;
   logic                            csr_ready;
   logic [llca_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [llca_pkg::CSR_DATA_W-1:0] csr_data;

   // predictor state: grid contents and a shadow of the registers
   bit          cell_grid [CELL_COUNT];
   logic [6:0]  width_reg   = llca_pkg::GRID_WIDTH_RST;
   logic [6:0]  height_reg  = llca_pkg::GRID_HEIGHT_RST;
   bit          wrap_reg    = llca_pkg::EDGE_WRAP_RST;
   logic [8:0]  birth_reg   = llca_pkg::BIRTH_MASK_RST;
   logic [8:0]  survive_reg = llca_pkg::SURVIVE_MASK_RST;

   cell_reply_type replies_due [$];
   stim_row_type   directed_rows [$];
   int             mismatch_count = 0;
   bit             tail_quiet = 0;   // no idling on either side in the last phase
   bit             csr_busy = 0;     // csr_valid still high after the last write

   life_like_cellular_automaton_top #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous cap on the length of the run
   initial begin
      #4_800_000;
      $display("tb failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // register value to active extent: zero counts as one, large saturates
   function automatic int span(logic [6:0] v, int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   // cell index for a coordinate, wrapped or bounds-checked per edge mode
   function automatic bit find_cell(int c, int r, output int idx);
      int w, h, wc, wr;
      w   = span(width_reg, MAX_COLS);
      h   = span(height_reg, MAX_ROWS);
      idx = 0;
      if (wrap_reg) begin
         wc = c % w;
         wr = r % h;
         if (wc < 0) wc += w;
         if (wr < 0) wr += h;
         idx = wr * MAX_COLS + wc;
         return 1'b1;
      end
      if (c < 0 || r < 0 || c >= w || r >= h) return 1'b0;
      idx = r * MAX_COLS + c;
      return 1'b1;
   endfunction

   // one generation over the active grid; cells outside it are untouched.
   // on tiny wrapped grids a neighbour that lands on the same cell twice
   // is counted once per offset
   function automatic void step_generation();
      bit nxt [CELL_COUNT];
      int w, h, r, c, dr, dc, nb, live, idx;
      w = span(width_reg, MAX_COLS);
      h = span(height_reg, MAX_ROWS);
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            live = 0;
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  if (!(dr == 0 && dc == 0) && find_cell(c + dc, r + dr, nb))
                     if (cell_grid[nb]) live++;
               end
            end
            idx      = r * MAX_COLS + c;
            nxt[idx] = cell_grid[idx] ? survive_reg[live] : birth_reg[live];
         end
      end
      for (r = 0; r < h; r++)
         for (c = 0; c < w; c++)
            cell_grid[r * MAX_COLS + c] = nxt[r * MAX_COLS + c];
   endfunction

   // applies one accepted word to the grid and returns the reply it causes
   function automatic cell_reply_type apply_word(llca_pkg::kind_type k,
                                                 logic [7:0] c, logic [7:0] r);
      cell_reply_type reply;
      int idx;
      reply    = '0;
      reply.ok = 1'b1;
      case (k) inside
         llca_pkg::KIND_TOGGLE, llca_pkg::KIND_READ: begin
            if (find_cell(int'(c), int'(r), idx)) begin
               if (k == llca_pkg::KIND_TOGGLE) cell_grid[idx] = !cell_grid[idx];
               reply.cell_value = cell_grid[idx];
            end else begin
               reply.ok = 1'b0;
            end
         end
         llca_pkg::KIND_CLEAR: begin
            foreach (cell_grid[i]) cell_grid[i] = 1'b0;
         end
         default: begin
            step_generation();
         end
      endcase
      return reply;
   endfunction

   // ------------------------------------------------------------------
   // directed table helpers
   // ------------------------------------------------------------------

   function automatic stim_row_type reg_row(llca_pkg::csr_index_type a, int v);
      stim_row_type s;
      s        = '0;
      s.is_csr = 1'b1;
      s.addr   = a;
      s.value  = 9'(v);
      return s;
   endfunction

   function automatic stim_row_type word_row(llca_pkg::kind_type k, int c, int r);
      stim_row_type s;
      s      = '0;
      s.kind = k;
      s.col  = 8'(c);
      s.row  = 8'(r);
      return s;
   endfunction

   function automatic stim_row_type known_row(llca_pkg::kind_type k, int c, int r,
                                              bit ok, bit val);
      stim_row_type s;
      s         = word_row(k, c, r);
      s.known   = 1'b1;
      s.exp_ok  = ok;
      s.exp_val = val;
      return s;
   endfunction

   // grid extent pick: mostly small, with the corners of the register
   function automatic logic [8:0] pick_extent();
      case ($urandom_range(0, 9))
         6:       return 9'($urandom_range(1, 2));
         7:       return 9'd64;
         8:       return 9'd127;   // saturates
         9:       return 9'd0;     // treated as one
         default: return 9'($urandom_range(3, 12));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // drops the request side and waits until every reply is back
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // one register write; csr_valid stays up until the next word goes out
   task automatic write_reg(llca_pkg::csr_index_type a, logic [8:0] v);
      csr_valid <= 1'b1;
      csr_addr  <= a;
      csr_data  <= v;
      csr_busy   = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (a)
         llca_pkg::CSR_GRID_WIDTH:   width_reg   = v[6:0];
         llca_pkg::CSR_GRID_HEIGHT:  height_reg  = v[6:0];
         llca_pkg::CSR_EDGE_WRAP:    wrap_reg    = v[0];
         llca_pkg::CSR_BIRTH_MASK:   birth_reg   = v;
         llca_pkg::CSR_SURVIVE_MASK: survive_reg = v;
         default: ;
      endcase
   endtask

   // sends one request word, now and then after a random gap, and queues
   // the reply it should produce
   task automatic send_word(llca_pkg::kind_type k, logic [7:0] c, logic [7:0] r,
                            bit known, bit k_ok, bit k_val);
      cell_reply_type reply;
      if (csr_busy) begin
         csr_valid <= 1'b0;
         csr_busy   = 1'b0;
      end
      if (!tail_quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {r, c};
      do @(posedge clock); while (!req_tready);
      reply = apply_word(k, c, r);
      if (known) begin
         reply.ok         = k_ok;
         reply.cell_value = k_val;
      end
      replies_due.push_back(reply);
   endtask

   // ------------------------------------------------------------------
   // reply side: random stall bursts, then checking of every reply
   // ------------------------------------------------------------------

   function automatic void flag_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
   endfunction

   initial begin : reply_stall
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (tail_quiet) begin
            rsp_tready <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            hold_left   = int'($urandom_range(1, 16)) - 1;
         end else begin
            rsp_tready <= 1'b1;
            hold_left   = int'($urandom_range(1, 24)) - 1;
         end
      end
   end

   always @(posedge clock) begin : reply_check
      cell_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            flag_mismatch("unexpected reply word", 0, int'(rsp_tdata));
         end else begin
            want = replies_due.pop_front();
            if (rsp_tdata[0] !== want.ok)
               flag_mismatch("ok", int'(want.ok), int'(rsp_tdata[0]));
            if (rsp_tdata[1] !== want.cell_value)
               flag_mismatch("cell_value", int'(want.cell_value), int'(rsp_tdata[1]));
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin : main_flow
      stim_row_type       s;
      int                 phase, n, w, h, pick;
      llca_pkg::kind_type k;
      logic [7:0]         c, r;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_addr   = '0;
      csr_data   = '0;

      // reset state, bounded 64x64 grid, b3/s23
      directed_rows.push_back(known_row(llca_pkg::KIND_READ,     0,   0, 1, 0));
      directed_rows.push_back(known_row(llca_pkg::KIND_READ,    63,  63, 1, 0));
      directed_rows.push_back(known_row(llca_pkg::KIND_READ,    64,   0, 0, 0));  // just off
      directed_rows.push_back(known_row(llca_pkg::KIND_TOGGLE, 255, 255, 0, 0));  // no change
      directed_rows.push_back(known_row(llca_pkg::KIND_TOGGLE,   0,   0, 1, 1));
      directed_rows.push_back(known_row(llca_pkg::KIND_TOGGLE,  63,  63, 1, 1));
      directed_rows.push_back(known_row(llca_pkg::KIND_READ,     0,   0, 1, 1));
      // horizontal blinker, flips to vertical in one generation
      directed_rows.push_back(known_row(llca_pkg::KIND_TOGGLE,  10,  10, 1, 1));
      directed_rows.push_back(known_row(llca_pkg::KIND_TOGGLE,  11,  10, 1, 1));
      directed_rows.push_back(known_row(llca_pkg::KIND_TOGGLE,  12,  10, 1, 1));
      directed_rows.push_back(known_row(llca_pkg::KIND_ADVANCE,  0,   0, 1, 0));
      directed_rows.push_back(word_row(llca_pkg::KIND_READ,     11,   9));
      directed_rows.push_back(word_row(llca_pkg::KIND_READ,     10,  10));
      directed_rows.push_back(word_row(llca_pkg::KIND_READ,      0,   0));  // lone corner died
      directed_rows.push_back(known_row(llca_pkg::KIND_CLEAR,    0,   0, 1, 0));
      directed_rows.push_back(known_row(llca_pkg::KIND_READ,    11,   9, 1, 0));
      // width zero acts as one column, height beyond max saturates, wrap on
      directed_rows.push_back(reg_row(llca_pkg::CSR_GRID_WIDTH, 0));
      directed_rows.push_back(reg_row(llca_pkg::CSR_GRID_HEIGHT, 127));
      directed_rows.push_back(reg_row(llca_pkg::CSR_EDGE_WRAP, 1));
      directed_rows.push_back(word_row(llca_pkg::KIND_TOGGLE,  200,   5));
      directed_rows.push_back(word_row(llca_pkg::KIND_READ,    255, 255));
      directed_rows.push_back(word_row(llca_pkg::KIND_ADVANCE,   0,   0));
      directed_rows.push_back(word_row(llca_pkg::KIND_READ,      0,   5));
      // 3x3 torus, every count births, nothing survives
      directed_rows.push_back(reg_row(llca_pkg::CSR_GRID_WIDTH, 3));
      directed_rows.push_back(reg_row(llca_pkg::CSR_GRID_HEIGHT, 3));
      directed_rows.push_back(reg_row(llca_pkg::CSR_BIRTH_MASK, 511));
      directed_rows.push_back(reg_row(llca_pkg::CSR_SURVIVE_MASK, 0));
      directed_rows.push_back(word_row(llca_pkg::KIND_TOGGLE,    4,   4));
      directed_rows.push_back(word_row(llca_pkg::KIND_ADVANCE,   0,   0));
      directed_rows.push_back(word_row(llca_pkg::KIND_READ,      0,   0));
      // bounded full grid, no births, everything survives
      directed_rows.push_back(reg_row(llca_pkg::CSR_EDGE_WRAP, 0));
      directed_rows.push_back(reg_row(llca_pkg::CSR_BIRTH_MASK, 0));
      directed_rows.push_back(reg_row(llca_pkg::CSR_SURVIVE_MASK, 511));
      directed_rows.push_back(reg_row(llca_pkg::CSR_GRID_WIDTH, 64));
      directed_rows.push_back(reg_row(llca_pkg::CSR_GRID_HEIGHT, 64));
      directed_rows.push_back(word_row(llca_pkg::KIND_ADVANCE,   0,   0));
      directed_rows.push_back(word_row(llca_pkg::KIND_READ,      1,   1));
      directed_rows.push_back(known_row(llca_pkg::KIND_READ,   128, 128, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         s = directed_rows[i];
         if (s.is_csr) begin
            quiesce();
            write_reg(s.addr, s.value);
         end else begin
            send_word(s.kind, s.col, s.row, s.known, s.exp_ok, s.exp_val);
         end
      end

      // random phases, each with a fresh register setting
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         quiesce();
         tail_quiet = (phase == RAND_PHASES - 1);
         write_reg(llca_pkg::CSR_GRID_WIDTH, pick_extent());
         write_reg(llca_pkg::CSR_GRID_HEIGHT, pick_extent());
         write_reg(llca_pkg::CSR_EDGE_WRAP, 9'($urandom_range(0, 1)));
         write_reg(llca_pkg::CSR_BIRTH_MASK,
                   $urandom_range(0, 1) ? llca_pkg::BIRTH_MASK_RST
                                        : 9'($urandom_range(0, 511)));
         write_reg(llca_pkg::CSR_SURVIVE_MASK,
                   $urandom_range(0, 1) ? llca_pkg::SURVIVE_MASK_RST
                                        : 9'($urandom_range(0, 511)));
         w = span(width_reg, MAX_COLS);
         h = span(height_reg, MAX_ROWS);
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = int'($urandom_range(0, 19));
            if (pick < 9)       k = llca_pkg::KIND_TOGGLE;
            else if (pick < 15) k = llca_pkg::KIND_READ;
            else if (pick < 18) k = llca_pkg::KIND_ADVANCE;
            else if (pick < 19) k = llca_pkg::KIND_CLEAR;
            else                k = llca_pkg::kind_type'($urandom_range(0, 3));
            // mostly on the grid or one past it, sometimes anywhere
            if ($urandom_range(0, 4) == 0) begin
               c = 8'($urandom_range(0, 255));
               r = 8'($urandom_range(0, 255));
            end else begin
               c = 8'($urandom_range(0, w));
               r = 8'($urandom_range(0, h));
               if ($urandom_range(0, 3) != 0 && int'(c) >= w) c = 8'(w - 1);
               if ($urandom_range(0, 3) != 0 && int'(r) >= h) r = 8'(h - 1);
            end
            send_word(k, c, r, 1'b0, 1'b0, 1'b0);
         end
      end

      quiesce();
      if (csr_busy) csr_valid <= 1'b0;
      // catch any stray reply after the last one expected
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ----- life_like_cellular_automaton_top.f -----
design/llca_pkg.sv
design/llca_dp.sv
design/llca_ctrl.sv
design/life_like_cellular_automaton_top.sv
dv/tb.sv
